[rtl/kpct_pkg.sv]
// kpct_pkg: shared types, codes and constants for the keyed pass counter table
// used by kpct_ctrl, kpct_datapath and keyed_pass_counter_table
package kpct_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_CHARS    = 6;
    localparam int KEY_W        = 48;
    localparam int COUNT_W      = 16;
    localparam int CHAR_W       = 8;
    localparam int OP_W         = 2;

    localparam logic [OP_W-1:0] OP_PASS   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNFLAG = 2'd1;
    localparam logic [OP_W-1:0] OP_STATUS = 2'd2;

    localparam logic [CHAR_W-1:0]  UNFLAG_CHAR = 8'h52;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE   = 16'd1;

    // characters beyond the key length are dropped
    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_CHARS * 8 >= KEY_W) ? {KEY_W{1'b1}} :
        ((KEY_W'(1) << (8 * KEY_CHARS)) - KEY_W'(1));

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [KEY_W-1:0]  plate_key;
        logic [CHAR_W-1:0] new_state_char;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [KEY_W-1:0]   echo_key;
        logic [COUNT_W-1:0] pass_count;
        logic [CHAR_W-1:0]  state_char;
    } t_result;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [CHAR_W-1:0]  state_char;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic cmp;
        logic inc;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic match;
        logic last;
    } t_stat;

endpackage

[rtl/kpct_ctrl.sv]
// kpct_ctrl: sequencer that walks the entry memory for one request at a time
// depends on kpct_pkg for the command and status types
module kpct_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  kpct_pkg::t_stat i_stat,
    output kpct_pkg::t_cmd  o_cmd
);
    import kpct_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_CMP    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.empty ? ST_FINISH : ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_stat.match || i_stat.last) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = ST_READ;
                end
            end
            ST_FINISH: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

[rtl/kpct_datapath.sv]
// kpct_datapath: entry memory, fill count, scan index, key compare and result register
// depends on kpct_pkg; driven by kpct_ctrl commands
module kpct_datapath #(
    parameter int CAPACITY = kpct_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kpct_pkg::t_req    i_req,
    input  kpct_pkg::t_cmd    i_cmd,
    output kpct_pkg::t_stat   o_stat,
    output logic              o_done,
    output kpct_pkg::t_result o_result
);
    import kpct_pkg::*;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FILL_W = $clog2(CAPACITY + 1);

    t_entry r_mem [CAPACITY];

    t_req              r_req;
    t_entry            r_rd;
    logic [IDX_W-1:0]  r_idx;
    logic [FILL_W-1:0] r_fill;
    logic              r_hit;
    logic              r_done;
    t_result           r_result;

    logic              full;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic [COUNT_W-1:0] count_inc;

    assign full      = (r_fill == FILL_W'(CAPACITY));
    assign count_inc = (r_rd.count == COUNT_MAX) ? COUNT_MAX : r_rd.count + COUNT_ONE;

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.match = (r_rd.key == r_req.plate_key);
    assign o_stat.last  = ((FILL_W + 1)'(r_idx) + (FILL_W + 1)'(1)) == (FILL_W + 1)'(r_fill);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_hit ? r_idx : IDX_W'(r_fill);
        wr_data = r_rd;
        case (r_req.operation)
            OP_PASS: begin
                wr_en              = i_cmd.commit && (r_hit || !full);
                wr_data.key        = r_req.plate_key;
                wr_data.count      = r_hit ? count_inc : COUNT_ONE;
                wr_data.state_char = r_req.new_state_char;
            end
            OP_UNFLAG: begin
                wr_en              = i_cmd.commit && r_hit;
                wr_data.state_char = UNFLAG_CHAR;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req.operation      <= i_req.operation;
            r_req.plate_key      <= i_req.plate_key & KEY_MASK;
            r_req.new_state_char <= i_req.new_state_char;
        end
        if (i_cmd.commit) begin
            r_result.found      <= r_hit;
            r_result.echo_key   <= r_req.plate_key;
            r_result.pass_count <= r_hit ? r_rd.count : '0;
            r_result.state_char <= r_hit ? r_rd.state_char : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_idx  <= '0;
            r_hit  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.commit && (r_req.operation == OP_STATUS);
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else if (i_cmd.inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (i_cmd.cmp && o_stat.match) begin
                r_hit <= 1'b1;
            end
            // a new key lands in the next free slot
            if (i_cmd.commit && r_req.operation == OP_PASS && !r_hit && !full) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[rtl/keyed_pass_counter_table.sv]
// keyed_pass_counter_table: top level joining the sequencer and the datapath
// depends on kpct_pkg, kpct_ctrl and kpct_datapath
//
//   channel   ports                     handshake
//   request   start, busy, i_req        taken when start is high and busy is low
//   result    o_done, o_result          one cycle strobe, status requests only
//
// a request walks the occupied entries in fill order, a read state then a
// compare state per entry, stopping at the first match or the last entry; busy
// stays high through the read, compare and finish states (an empty table goes
// from idle straight to finish); the entry memory has a single, registered read port
// the result strobe rises at the edge where busy falls; reset empties the table
// at once through the fill count; the result side cannot stall
module keyed_pass_counter_table #(
    parameter int CAPACITY = kpct_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  kpct_pkg::t_req    i_req,
    output logic              o_done,
    output kpct_pkg::t_result o_result
);
    import kpct_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    kpct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    kpct_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for keyed_pass_counter_table
// drives pass, unflag and status requests, predicts the table contents in the bench
// and checks every status result in order; depends on kpct_pkg and the rtl top level
module tb_top;
    import kpct_pkg::*;

    localparam int      TABLE_DEPTH  = CAPACITY_DEF;
    localparam longint  CYCLE_LIMIT  = 4_000_000;
    localparam int      RANDOM_ITEMS = 1400;
    localparam int      POOL_SIZE    = 96;
    localparam logic [KEY_W-1:0] SAT_PLATE = 48'h4B50_3030_3031;
    localparam logic [KEY_W-1:0] ZERO_PLATE = '0;
    localparam logic [KEY_W-1:0] ONES_PLATE = '1;
    localparam logic [OP_W-1:0]  OP_UNUSED  = 2'd3;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_req    i_req;
    logic    o_done;
    t_result o_result;

    keyed_pass_counter_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // bench copy of the table
    logic [KEY_W-1:0]   tbl_key   [TABLE_DEPTH];
    logic               tbl_valid [TABLE_DEPTH];
    logic [COUNT_W-1:0] tbl_count [TABLE_DEPTH];
    logic [CHAR_W-1:0]  tbl_state [TABLE_DEPTH];
    int                 tbl_fill;

    t_result          status_expect_q[$];
    logic [KEY_W-1:0] plate_pool[POOL_SIZE];

    longint cycle_cnt;
    int     mismatch_cnt;
    int     error_cnt;
    int     requests_sent;
    int     status_checked;
    int     dropped_inserts;
    bit     no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, status_expect_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // works out the effect of one request on the table and the status it returns
    function automatic void table_apply(input t_req r, output bit has_res,
                                        output t_result res);
        logic [KEY_W-1:0] k;
        int slot;
        k = r.plate_key & KEY_MASK;
        slot = -1;
        has_res = 1'b0;
        res = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot < 0 && tbl_valid[i] && tbl_key[i] == k) slot = i;
        end
        case (r.operation)
            OP_PASS: begin
                if (slot >= 0) begin
                    if (tbl_count[slot] != COUNT_MAX) tbl_count[slot] = tbl_count[slot] + 1'b1;
                    tbl_state[slot] = r.new_state_char;
                end else if (tbl_fill < TABLE_DEPTH) begin
                    tbl_key[tbl_fill]   = k;
                    tbl_count[tbl_fill] = COUNT_ONE;
                    tbl_state[tbl_fill] = r.new_state_char;
                    tbl_valid[tbl_fill] = 1'b1;
                    tbl_fill++;
                end else begin
                    dropped_inserts++;
                end
            end
            OP_UNFLAG: begin
                if (slot >= 0) tbl_state[slot] = UNFLAG_CHAR;
            end
            OP_STATUS: begin
                has_res = 1'b1;
                res.found      = (slot >= 0);
                res.echo_key   = k;
                res.pass_count = (slot >= 0) ? tbl_count[slot] : '0;
                res.state_char = (slot >= 0) ? tbl_state[slot] : '0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done) begin
            if (status_expect_q.size() == 0) begin
                error_cnt++;
                $display("unexpected status result key=%h", o_result.echo_key);
            end else begin
                want = status_expect_q.pop_front();
                status_checked++;
                if (o_result.found !== want.found || o_result.echo_key !== want.echo_key ||
                    o_result.pass_count !== want.pass_count ||
                    o_result.state_char !== want.state_char) begin
                    mismatch_cnt++;
                    error_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp found=%b key=%h cnt=%0d st=%h, got found=%b key=%h cnt=%0d st=%h",
                                 want.found, want.echo_key, want.pass_count, want.state_char,
                                 o_result.found, o_result.echo_key, o_result.pass_count,
                                 o_result.state_char);
                end
            end
        end
    end

    // start is left high after acceptance so back-to-back requests need one assignment
    task automatic send_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                            input logic [CHAR_W-1:0] ch);
        t_req    r;
        bit      has_res;
        t_result res;
        r.operation      = op;
        r.plate_key      = key;
        r.new_state_char = ch;
        if (!no_idle && $urandom_range(99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        table_apply(r, has_res, res);
        if (has_res) status_expect_q.push_back(res);
        requests_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (status_expect_q.size() != 0);
    endtask

    function automatic logic [KEY_W-1:0] random_plate();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[KEY_W-1:0];
    endfunction

    task automatic build_plate_pool();
        logic [KEY_W-1:0] p;
        logic [CHAR_W-1:0] c;
        int len;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < 80) begin
                // registration style plates, shorter ones zero padded at the end
                len = $urandom_range(3, 6);
                p = '0;
                for (int j = 0; j < KEY_CHARS; j++) begin
                    if (j < len)
                        c = $urandom_range(1) ? CHAR_W'(8'h41 + $urandom_range(25))
                                              : CHAR_W'(8'h30 + $urandom_range(9));
                    else
                        c = '0;
                    p = {p[KEY_W-CHAR_W-1:0], c};
                end
                plate_pool[i] = p;
            end else begin
                plate_pool[i] = random_plate();
            end
        end
    endtask

    task automatic apply_reset();
        start   <= 1'b0;
        i_req   <= '0;
        i_rst_n <= 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_count[i] = '0;
            tbl_state[i] = '0;
        end
        tbl_fill = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic test_empty_table();
        send_req(OP_STATUS, ZERO_PLATE, 8'h00);
        send_req(OP_STATUS, ONES_PLATE, 8'hFF);
        send_req(OP_UNFLAG, SAT_PLATE, 8'h00);
        send_req(OP_UNUSED, SAT_PLATE, 8'h47);
        send_req(OP_STATUS, SAT_PLATE, 8'h00);
        send_req(OP_PASS, SAT_PLATE, 8'h47);
        send_req(OP_STATUS, SAT_PLATE, 8'h00);
    endtask

    // the repeated key sits in the first slot so each request is short
    task automatic test_repeated_pass();
        repeat (100) send_req(OP_PASS, SAT_PLATE, CHAR_W'($urandom_range(255)));
        send_req(OP_STATUS, SAT_PLATE, 8'h00);
        send_req(OP_PASS, SAT_PLATE, 8'h4F);
        send_req(OP_STATUS, SAT_PLATE, 8'h00);
        repeat (3) send_req(OP_PASS, SAT_PLATE, 8'h50);
        send_req(OP_STATUS, SAT_PLATE, 8'h00);
    endtask

    task automatic test_field_extremes();
        send_req(OP_PASS, ZERO_PLATE, 8'h00);
        send_req(OP_PASS, ONES_PLATE, 8'hFF);
        send_req(OP_STATUS, ZERO_PLATE, 8'hFF);
        send_req(OP_STATUS, ONES_PLATE, 8'h00);
        send_req(OP_UNFLAG, ZERO_PLATE, 8'h00);
        send_req(OP_STATUS, ZERO_PLATE, 8'h00);
        send_req(OP_UNFLAG, 48'h5A5A_5A5A_5A5A, 8'hAA);
        send_req(OP_UNUSED, ONES_PLATE, 8'h11);
        send_req(OP_STATUS, ONES_PLATE, 8'h00);
        send_req(OP_PASS, ONES_PLATE, 8'h41);
        send_req(OP_STATUS, ONES_PLATE, 8'h00);
        send_req(OP_STATUS, 48'h5A5A_5A5A_5A5A, 8'h00);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int pick;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 600 && n < 900);
            pick = $urandom_range(99);
            if (pick < 45)      op = OP_PASS;
            else if (pick < 60) op = OP_UNFLAG;
            else if (pick < 95) op = OP_STATUS;
            else                op = OP_UNUSED;
            key = ($urandom_range(99) < 85) ? plate_pool[$urandom_range(POOL_SIZE - 1)]
                                            : random_plate();
            send_req(op, key, CHAR_W'($urandom_range(255)));
            if (n % 200 == 199) wait_drained();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_table_full();
        logic [KEY_W-1:0] fresh;
        while (tbl_fill < TABLE_DEPTH) send_req(OP_PASS, random_plate(), 8'h4E);
        for (int i = 0; i < 4; i++) begin
            fresh = random_plate();
            send_req(OP_PASS, fresh, 8'h44);
            send_req(OP_STATUS, fresh, 8'h00);
            send_req(OP_UNFLAG, fresh, 8'h00);
        end
        send_req(OP_STATUS, tbl_key[TABLE_DEPTH - 1], 8'h00);
        send_req(OP_PASS, tbl_key[TABLE_DEPTH - 1], 8'h5A);
        send_req(OP_STATUS, tbl_key[TABLE_DEPTH - 1], 8'h00);
        send_req(OP_STATUS, SAT_PLATE, 8'h00);
    endtask

    initial begin
        cycle_cnt       = 0;
        mismatch_cnt    = 0;
        error_cnt       = 0;
        requests_sent   = 0;
        status_checked  = 0;
        dropped_inserts = 0;
        no_idle         = 1'b0;
        build_plate_pool();
        apply_reset();

        test_empty_table();
        test_repeated_pass();
        test_field_extremes();
        test_random_traffic();
        test_table_full();

        start <= 1'b0;
        for (int w = 0; w < 2000 && status_expect_q.size() != 0; w++) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (status_expect_q.size() != 0) begin
            error_cnt++;
            $display("%0d status results never arrived", status_expect_q.size());
        end

        $display("%0d requests sent, %0d status results checked, %0d mismatches",
                 requests_sent, status_checked, mismatch_cnt);
        $display("covered repeated passes, %0d dropped inserts on a full table, unflag, unused code",
                 dropped_inserts);
        if (error_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
